// ----- rtl/core/modem_reply_recognizer_assert.svh -----
// Assertion macros for the modem reply recognizer checker.
// Included by the checker file only.
`ifndef MODEM_REPLY_RECOGNIZER_ASSERT_SVH
`define MODEM_REPLY_RECOGNIZER_ASSERT_SVH
`define MRR_ASSERT_IMPLIES(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("mrr check failed");
`define MRR_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("mrr check failed");
`endif

// ----- rtl/core/mrr_pkg.sv -----
// Package for the modem reply recognizer: pattern table, types, codes.
// No dependencies.
package mrr_pkg;
   localparam int PatCount = 16;
   localparam int PatMax   = 25;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DROP, ST_SHIFT, ST_EMIT
   } state_type;

   typedef struct packed {
      logic [3:0]  pattern_index;
      logic [6:0]  signal_quality;
      logic [1:0]  sim_state;
      logic        first_ready;
      logic        link_up;
      logic [2:0]  connect_step;
      logic [1:0]  reply_status;
      logic [2:0]  operator_profile;
      logic [47:0] server_time;
   } rsp_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_type;

   // control from sequencer to window cells; load_pos covers up to 256 cells
   typedef struct packed {
      logic       load;
      logic       shift;
      logic [7:0] load_pos;
   } win_ctl_type;

   function automatic logic [4:0] pat_len(input logic [3:0] i);
      case (i)
         4'd0: pat_len = 5'd12;  4'd1: pat_len = 5'd6;   4'd2: pat_len = 5'd4;
         4'd3: pat_len = 5'd2;   4'd4: pat_len = 5'd5;   4'd5: pat_len = 5'd11;
         4'd6: pat_len = 5'd25;  4'd7: pat_len = 5'd9;   4'd8: pat_len = 5'd9;
         4'd9: pat_len = 5'd7;   4'd14: pat_len = 5'd11; 4'd15: pat_len = 5'd10;
         default: pat_len = 5'd5;
      endcase
   endfunction

   function automatic logic [8*PatMax-1:0] pat_text(input logic [3:0] i);
      case (i)
         4'd0: pat_text = "+CPIN: READY";
         4'd1: pat_text = "+CSQ: ";
         4'd2: pat_text = "GSV,";
         4'd3: pat_text = "OK";
         4'd4: pat_text = "45201";
         4'd5: pat_text = "+NETOPEN: 1";
         4'd6: pat_text = "Network is already opened";
         4'd7: pat_text = "+IPCLOSE:";
         4'd8: pat_text = "+CIPOPEN:";
         4'd9: pat_text = "CMD=|v|";
         4'd10: pat_text = "45204";
         4'd11: pat_text = "45202";
         4'd12: pat_text = "45207";
         4'd13: pat_text = "45205";
         4'd14: pat_text = "SIM REMOVED";
         default: pat_text = "+CME ERROR";
      endcase
   endfunction

   // byte j of pattern i (string is right aligned)
   function automatic logic [7:0] pat_byte(input logic [3:0] i, input logic [4:0] j);
      logic [8*PatMax-1:0] t;
      logic [4:0] l;
      logic [5:0] p;
      t = pat_text(i);
      l = pat_len(i);
      p = 6'(l) - 6'(j) - 6'd1;
      pat_byte = t[p*8 +: 8];
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      is_digit = (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic [6:0] parse_quality(input logic [7:0] a, input logic [7:0] b);
      logic [3:0] da, db;
      da = a[3:0];
      db = b[3:0];
      if (is_digit(a)) begin
         if (is_digit(b)) parse_quality = 7'(da) * 7'd10 + 7'(db);
         else parse_quality = 7'(da);
      end else if ((a == 8'h20 || a == 8'h2b || (a >= 8'd9 && a <= 8'd13)) && is_digit(b))
         parse_quality = 7'(db);
      else parse_quality = 7'd0;
   endfunction
endpackage

// ----- rtl/core/mrr_if.sv -----
// Valid/ready channel interface for the modem reply recognizer.
// Uses nothing else.
interface mrr_if #(parameter int W = 8) (input logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/modem_reply_recognizer.sv -----
// Modem reply recognizer.
// Request channel req (rx_byte), response channel rsp (match record).
// A byte enters a row of WINDOW_DEPTH byte cells; cell 0 is the oldest.
// A sequencer then tries the 16 patterns at cell 0, one byte compare per
// cycle; a miss moves on to the next pattern from its first byte. A
// position that fails all patterns is dropped by one shift and the next
// position is scanned again. A match shifts out its consumed bytes one per
// cycle (up to 25), then ST_EMIT loads the output register once the
// previous response has been taken. A byte that only extends a partial
// reply returns the sequencer to idle to wait for more bytes. At most one
// response per request.
// A response sits in an output register; the next request is accepted
// only after the previous request has finished, and while the response
// is held (stalled receiver) no new scan starts.
// Synchronous reset clears the count, link state (SIM unknown) and control.
// Window cells are not reset; only cells below the count are read.
module modem_reply_recognizer #(
   parameter int WINDOW_DEPTH = 32
) (
   input logic clock,
   input logic reset,
   mrr_if.sink   req,
   mrr_if.source rsp
);
   import mrr_pkg::*;
   localparam int CntW = $clog2(WINDOW_DEPTH + 1);
   localparam int PosW = $clog2(WINDOW_DEPTH);

   win_ctl_type ctl;
   logic [7:0] cells [WINDOW_DEPTH];

   for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      logic [7:0] rb;
      if (g == WINDOW_DEPTH - 1) begin : g_end
         assign rb = 8'h00;
      end else begin : g_mid
         assign rb = cells[g+1];
      end
      mrr_cell #(.PosW(PosW), .Pos(PosW'(g))) u_cell (
         .clock(clock), .ctl(ctl), .new_byte(req.payload[7:0]),
         .right_byte(rb), .data(cells[g]));
   end

   state_type state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [3:0] pat_ff, pat_in;
   logic [4:0] j_ff, j_in;
   logic [5:0] used_ff, used_in;  // bytes still to shift out
   logic [1:0] sim_ff, sim_in;
   logic [6:0] q_ff, q_in;
   logic [2:0] step_ff, step_in, prof_ff, prof_in;
   logic [1:0] stat_ff, stat_in;
   logic link_ff, link_in, first_ff, first_in;
   logic [47:0] tm_ff, tm_in;
   logic rv_ff, rv_in;
   rsp_type rsp_ff, rsp_in;
   logic emit_ff, emit_in; // send response after shifting

   logic [7:0] cur, pb;
   logic [4:0] plen;
   logic [CntW:0] need;

   // compare index never passes the longest pattern, well inside the row
   assign cur  = cells[PosW'(j_ff)];
   assign pb   = pat_byte(pat_ff, j_ff);
   assign plen = pat_len(pat_ff);

   assign req.ready = (state_ff == ST_IDLE) && !rv_ff && (count_ff < CntW'(WINDOW_DEPTH));
   assign rsp.valid = rv_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      state_in = state_ff; count_in = count_ff; pat_in = pat_ff; j_in = j_ff;
      used_in = used_ff; sim_in = sim_ff; q_in = q_ff; step_in = step_ff;
      prof_in = prof_ff; stat_in = stat_ff; link_in = link_ff; first_in = first_ff;
      tm_in = tm_ff; rv_in = rv_ff; rsp_in = rsp_ff; emit_in = emit_ff;
      ctl = '0;
      need = '0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               ctl.load = 1'b1;
               ctl.load_pos = 8'(count_ff);
               count_in = count_ff + 1'b1;
               state_in = ST_SCAN; pat_in = '0; j_in = '0;
            end
         end
         ST_SCAN: begin
            if (count_ff == '0) state_in = ST_IDLE;
            else if (j_ff < plen) begin
               if (CntW'(j_ff) >= count_ff) state_in = ST_IDLE; // wait
               else if (cur != pb) begin
                  j_in = '0;
                  if (pat_ff == 4'd15) state_in = ST_DROP;
                  else pat_in = pat_ff + 1'b1;
               end else j_in = j_ff + 1'b1;
            end else begin
               first_in = 1'b0; tm_in = '0;
               used_in = 6'(plen);
               emit_in = 1'b1;
               state_in = ST_SHIFT;
               case (pat_ff)
                  4'd1: begin
                     need = (CntW+1)'(plen) + (CntW+1)'(2);
                     if ({1'b0, count_ff} < need) state_in = ST_IDLE;
                     else if (cells[6] == 8'h2c) begin
                        q_in = '0; used_in = 6'd7;
                     end else begin
                        q_in = parse_quality(cells[6], cells[7]); used_in = 6'd8;
                     end
                  end
                  4'd9: begin
                     need = (CntW+1)'(plen) + (CntW+1)'(6);
                     if ({1'b0, count_ff} < need) state_in = ST_IDLE;
                     else begin
                        tm_in = {cells[7], cells[8], cells[9], cells[10], cells[11],
                                 cells[12]};
                        used_in = 6'd13;
                     end
                  end
                  4'd0: if (sim_ff != 2'd1) begin
                     sim_in = 2'd1; step_in = '0; first_in = 1'b1;
                  end
                  4'd3: stat_in = 2'd1;
                  4'd5: begin stat_in = 2'd2; step_in = 3'd5; end
                  4'd6: step_in = 3'd5;
                  4'd7: step_in = 3'd0;
                  4'd8: link_in = 1'b1;
                  4'd14, 4'd15: begin sim_in = '0; q_in = '0; end
                  4'd4: begin prof_in = 3'd1; step_in = 3'd1; end
                  4'd10, 4'd13: begin prof_in = 3'd2; step_in = 3'd1; end
                  4'd11: begin prof_in = 3'd3; step_in = 3'd1; end
                  4'd12: begin prof_in = 3'd4; step_in = 3'd1; end
                  default: ;
               endcase
               if (state_in == ST_IDLE) emit_in = 1'b0;
            end
         end
         ST_DROP: begin
            ctl.shift = 1'b1;
            count_in = count_ff - 1'b1;
            state_in = ST_SCAN; pat_in = '0; j_in = '0;
         end
         ST_SHIFT: begin
            if (used_ff == '0) state_in = ST_EMIT;
            else begin
               ctl.shift = 1'b1;
               count_in = count_ff - 1'b1;
               used_in = used_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rv_ff) begin
               rv_in = 1'b1;
               rsp_in = '{pattern_index: pat_ff, signal_quality: q_ff, sim_state: sim_ff,
                  first_ready: first_ff, link_up: link_ff, connect_step: step_ff,
                  reply_status: stat_ff, operator_profile: prof_ff, server_time: tm_ff};
               emit_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; sim_ff <= 2'd2; q_ff <= '0;
         step_ff <= '0; prof_ff <= '0; stat_ff <= '0; link_ff <= 1'b0;
         rv_ff <= 1'b0; emit_ff <= 1'b0; first_ff <= 1'b0;
         pat_ff <= '0; j_ff <= '0; used_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; sim_ff <= sim_in; q_ff <= q_in;
         step_ff <= step_in; prof_ff <= prof_in; stat_ff <= stat_in; link_ff <= link_in;
         rv_ff <= rv_in; emit_ff <= emit_in; first_ff <= first_in;
         pat_ff <= pat_in; j_ff <= j_in; used_ff <= used_in;
      end
      tm_ff <= tm_in;
      rsp_ff <= rsp_in;
   end
endmodule

// ----- rtl/core/mrr_cell.sv -----
// One window cell: holds one byte, loads it, or takes its right neighbor's.
// Depends on mrr_pkg.
module mrr_cell #(
   parameter int PosW = 6,
   parameter logic [PosW-1:0] Pos = '0
) (
   input  logic                 clock,
   input  mrr_pkg::win_ctl_type ctl,
   input  logic [7:0]           new_byte,
   input  logic [7:0]           right_byte,
   output logic [7:0]           data
);
   import mrr_pkg::*;
   logic [7:0] data_ff, data_in;
   always_comb begin
      data_in = data_ff;
      if (ctl.shift) data_in = right_byte;
      else if (ctl.load && ctl.load_pos[PosW-1:0] == Pos) data_in = new_byte;
   end
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end
   assign data = data_ff;
endmodule

// ----- rtl/core/mrr_checker.sv -----
// Port-level checker for the modem reply recognizer, bound to the top.
// Depends on mrr_pkg and modem_reply_recognizer_assert.svh.
`include "modem_reply_recognizer_assert.svh"
module mrr_checker (
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_ready,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input mrr_pkg::rsp_type rsp_payload
);
   import mrr_pkg::*;
   `MRR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   `MRR_ASSERT_IMPLIES(a_no_accept_while_held, clock, reset, rsp_valid, !req_ready)
   `MRR_ASSERT_IMPLIES(a_sim_range, clock, reset, rsp_valid, rsp_payload.sim_state != 2'd3)
   `MRR_ASSERT_IMPLIES(a_time_only_p9, clock, reset, rsp_valid && rsp_payload.pattern_index != 4'd9, rsp_payload.server_time == 48'd0)
   `MRR_ASSERT_IMPLIES(a_first_p0, clock, reset, rsp_valid && rsp_payload.first_ready, rsp_payload.pattern_index == 4'd0 && rsp_payload.sim_state == 2'd1)
endmodule

bind modem_reply_recognizer mrr_checker u_mrr_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload));

// ----- sim/tb_modem_reply_recognizer.sv -----
// Testbench for modem_reply_recognizer: reply bytes in, match records checked
// against a behavioral reply parser. Depends on mrr_pkg, mrr_if and the RTL.
`timescale 1ns / 1ps
module tb_modem_reply_recognizer;
   import mrr_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_BYTES = 1300;
   localparam int WIN_DEPTH = 32;

   logic clock;
   logic reset;

   mrr_if #(.W($bits(req_type))) req_ch (clock);
   mrr_if #(.W($bits(rsp_type))) rsp_ch (clock);

   modem_reply_recognizer #(.WINDOW_DEPTH(WIN_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always #5 clock = ~clock;

   // reply texts in priority order
   string reply_text[16] = '{
      "+CPIN: READY", "+CSQ: ", "GSV,", "OK", "45201", "+NETOPEN: 1",
      "Network is already opened", "+IPCLOSE:", "+CIPOPEN:", "CMD=|v|",
      "45204", "45202", "45207", "45205", "SIM REMOVED", "+CME ERROR"
   };

   // parser state
   logic [7:0] rx_window[$];
   logic [1:0] sim_now;
   logic [6:0] quality_now;
   logic [2:0] step_now;
   logic [1:0] status_now;
   logic [2:0] profile_now;
   logic       link_now;

   rsp_type    match_queue[$];
   logic [7:0] byte_stream[$];
   rsp_type    typed_match[int];
   int         errors;
   int         cycle;

   function automatic bit is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic [6:0] quality_of(logic [7:0] a, logic [7:0] b);
      if (is_dig(a))
         return is_dig(b) ? 7'((a - "0") * 10 + (b - "0")) : 7'(a - "0");
      if ((a == " " || a == "+" || (a >= 8'd9 && a <= 8'd13)) && is_dig(b))
         return 7'(b - "0");
      return 7'd0;
   endfunction

   // 0 fail, 1 wait for more bytes, 2 full match
   function automatic int compare_reply(int i);
      for (int j = 0; j < reply_text[i].len(); j++) begin
         if (j >= rx_window.size()) return 1;
         if (rx_window[j] != reply_text[i][j]) return 0;
      end
      return 2;
   endfunction

   function automatic bit parse_byte(logic [7:0] b, output rsp_type r);
      int verdict;
      int used;
      logic [47:0] tm;
      bit first;
      r = '0;
      if (rx_window.size() < WIN_DEPTH) rx_window.push_back(b);
      while (rx_window.size() > 0) begin
         for (int i = 0; i < 16; i++) begin
            verdict = compare_reply(i);
            if (verdict == 1) return 0;
            if (verdict == 0) continue;
            used = reply_text[i].len();
            tm = '0;
            first = 0;
            case (i)
               1: begin
                  if (rx_window.size() - used < 2) return 0;
                  if (rx_window[used] == ",") begin
                     quality_now = 0;
                     used += 1;
                  end else begin
                     quality_now = quality_of(rx_window[used], rx_window[used+1]);
                     used += 2;
                  end
               end
               9: begin
                  if (rx_window.size() - used < 6) return 0;
                  for (int k = 0; k < 6; k++) tm = {tm[39:0], rx_window[used+k]};
                  used += 6;
               end
               0: if (sim_now != 2'd1) begin
                  sim_now = 2'd1;
                  step_now = 0;
                  first = 1;
               end
               3: status_now = 2'd1;
               5: begin
                  status_now = 2'd2;
                  step_now = 3'd5;
               end
               6: step_now = 3'd5;
               7: step_now = 0;
               8: link_now = 1;
               14, 15: begin
                  sim_now = 0;
                  quality_now = 0;
               end
               4: begin profile_now = 3'd1; step_now = 3'd1; end
               10, 13: begin profile_now = 3'd2; step_now = 3'd1; end
               11: begin profile_now = 3'd3; step_now = 3'd1; end
               12: begin profile_now = 3'd4; step_now = 3'd1; end
               default: ;
            endcase
            for (int k = 0; k < used && rx_window.size() > 0; k++) void'(rx_window.pop_front());
            r = '{pattern_index: 4'(i), signal_quality: quality_now, sim_state: sim_now,
                  first_ready: first, link_up: link_now, connect_step: step_now,
                  reply_status: status_now, operator_profile: profile_now,
                  server_time: tm};
            return 1;
         end
         void'(rx_window.pop_front());
      end
      return 0;
   endfunction

   task automatic check_field(string name, longint unsigned e, longint unsigned a);
      if (e !== a) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
         errors++;
      end
   endtask

   task automatic check_match(rsp_type e, rsp_type a);
      check_field("pattern_index", e.pattern_index, a.pattern_index);
      check_field("signal_quality", e.signal_quality, a.signal_quality);
      check_field("sim_state", e.sim_state, a.sim_state);
      check_field("first_ready", e.first_ready, a.first_ready);
      check_field("link_up", e.link_up, a.link_up);
      check_field("connect_step", e.connect_step, a.connect_step);
      check_field("reply_status", e.reply_status, a.reply_status);
      check_field("operator_profile", e.operator_profile, a.operator_profile);
      check_field("server_time", e.server_time, a.server_time);
   endtask

   function automatic logic [7:0] field_byte();
      case ($urandom_range(0, 7))
         0, 1, 2: return 8'("0" + $urandom_range(0, 9));
         3: return " ";
         4: return "+";
         5: return "-";
         6: return ",";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_text(string s);
      for (int j = 0; j < s.len(); j++) byte_stream.push_back(s[j]);
   endtask

   task automatic build_stimulus();
      int p;
      int cut;
      // directed rows; known records typed where obvious
      byte_stream.push_back(8'h00);
      byte_stream.push_back(8'hFF);
      add_text("OK");
      typed_match[byte_stream.size() - 1] = '{4'd3, 7'd0, 2'd2, 1'b0, 1'b0, 3'd0, 2'd1,
                                             3'd0, 48'd0};
      add_text("45201");
      typed_match[byte_stream.size() - 1] = '{4'd4, 7'd0, 2'd2, 1'b0, 1'b0, 3'd1, 2'd1,
                                             3'd1, 48'd0};
      add_text("+CSQ: 99");
      add_text("CMD=|v|");
      for (int k = 0; k < 6; k++) byte_stream.push_back(k[0] ? 8'hFF : 8'h00);
      while (byte_stream.size() < RANDOM_BYTES + 30) begin
         case ($urandom_range(0, 9))
            0: byte_stream.push_back(8'($urandom_range(0, 255)));
            1: begin
               // broken prefix
               p = $urandom_range(0, 15);
               cut = $urandom_range(1, reply_text[p].len() - 1);
               add_text(reply_text[p].substr(0, cut - 1));
            end
            default: begin
               p = $urandom_range(0, 15);
               add_text(reply_text[p]);
               if (p == 1) begin
                  byte_stream.push_back(field_byte());
                  byte_stream.push_back(field_byte());
               end else if (p == 9) begin
                  for (int k = 0; k < 6; k++) byte_stream.push_back(8'($urandom_range(0, 255)));
               end
            end
         endcase
      end
   endtask

   // sender: bursts and gaps; parser runs on each accepted request
   int sent;
   int burst_left;
   int gap_left;
   bit sender_done;

   always @(posedge clock) begin
      rsp_type r;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            if (parse_byte(byte_stream[sent], r)) begin
               if (typed_match.exists(sent)) check_match(typed_match[sent], r);
               match_queue.push_back(r);
            end
            sent++;
            if (burst_left > 0) burst_left--;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // keep offering
         end else if (sent >= byte_stream.size()) begin
            req_ch.valid <= 1'b0;
            sender_done = 1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
            req_ch.valid <= (gap_left == 0);
            req_ch.payload <= byte_stream[sent];
         end else begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= byte_stream[sent];
         end
      end
   end

   // receiver: changing stall pattern plus one long hold-off
   int hold_left;
   bit pressure_done;
   int stall_mode;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (cycle % 500 == 0) stall_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!pressure_done && cycle >= 4000) begin
            pressure_done = 1;
            hold_left = 3000;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= 1'($urandom_range(0, 1));
               2: rsp_ch.ready <= (cycle % 8) < 2;
               default: rsp_ch.ready <= $urandom_range(0, 7) != 0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (match_queue.size() == 0) begin
            $display("%0t: unexpected record, expected none, actual %0h", $time,
                     rsp_ch.payload);
            errors++;
         end else begin
            check_match(match_queue.pop_front(), rsp_type'(rsp_ch.payload));
         end
      end
   end

   always @(posedge clock) begin
      cycle++;
      if (cycle >= CYCLE_LIMIT) begin
         $display("tb_modem_reply_recognizer: FAIL");
         $finish;
      end
   end

   initial begin
      clock = 0;
      reset = 1;
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
      errors = 0;
      cycle = 0;
      sent = 0;
      burst_left = 0;
      gap_left = 0;
      sender_done = 0;
      hold_left = 0;
      pressure_done = 0;
      stall_mode = 0;
      rx_window.delete();
      sim_now = 2'd2;
      quality_now = 0;
      step_now = 0;
      status_now = 0;
      profile_now = 0;
      link_now = 0;
      build_stimulus();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (sender_done && match_queue.size() == 0);
      repeat (300) @(posedge clock);
      if (errors == 0 && match_queue.size() == 0)
         $display("tb_modem_reply_recognizer: PASS");
      else
         $display("tb_modem_reply_recognizer: FAIL");
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/mrr_pkg.sv
rtl/core/mrr_if.sv
rtl/core/mrr_cell.sv
rtl/core/modem_reply_recognizer.sv
rtl/core/mrr_checker.sv
sim/tb_modem_reply_recognizer.sv
